// ===== hdl/ptrs_pkg.sv =====
// Shared constants, types and register indexes for the periodic task release scheduler.
// No dependencies; the scheduler and ptrs_sort import this package.
`default_nettype none

package ptrs_pkg;

  localparam int TaskCount  = 3;
  localparam int Slots      = 3;
  localparam int KeyW       = 16;
  localparam int ElapsedW   = 17;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int MaskW      = 3;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  typedef logic [1:0] task_idx_t;
  typedef logic [Slots-1:0][KeyW-1:0] key_arr_t;
  typedef logic [Slots-1:0][1:0] order_arr_t;
  typedef logic [Slots-1:0][ElapsedW-1:0] elapsed_arr_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegOrderMode = 3'd0,
    RegTickStep  = 3'd1,
    RegPeriod0   = 3'd2,
    RegPeriod1   = 3'd3,
    RegPeriod2   = 3'd4,
    RegCost0     = 3'd5,
    RegCost1     = 3'd6,
    RegCost2     = 3'd7
  } reg_idx_e;

  localparam logic [KeyW-1:0] TickStepRst = 16'd50;
  localparam logic [KeyW-1:0] Period0Rst  = 16'd450;
  localparam logic [KeyW-1:0] Period1Rst  = 16'd200;
  localparam logic [KeyW-1:0] Period2Rst  = 16'd150;
  localparam logic [KeyW-1:0] Cost0Rst    = 16'd23;
  localparam logic [KeyW-1:0] Cost1Rst    = 16'd3;
  localparam logic [KeyW-1:0] Cost2Rst    = 16'd25;

endpackage

`default_nettype wire

// ===== hdl/ptrs_tick_if.sv =====
// Input channel carrying one tick item with valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface ptrs_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

`default_nettype wire

// ===== hdl/ptrs_result_if.sv =====
// Output channel carrying the release mask and priority order with valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface ptrs_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] release_mask;
  logic [1:0] first_task;
  logic [1:0] second_task;
  logic [1:0] third_task;

  modport source (output valid, output release_mask, output first_task,
                  output second_task, output third_task, input ready);
  modport sink (input valid, input release_mask, input first_task,
                input second_task, input third_task, output ready);
endinterface

`default_nettype wire

// ===== hdl/periodic_task_release_scheduler.sv =====
// Periodic release scheduler for three tasks with a fixed static priority order.
// Depends on ptrs_pkg, ptrs_tick_if, ptrs_result_if and ptrs_sort.
// Each result is registered and is valid in the cycle after its tick item is accepted.
// Throughput: one item per cycle while the output is taken; the elapsed-time compare/add per task sets the path.
// Reset: configuration returns to defaults and the block is idle; the first item
// loads each elapsed counter with its period and fixes the priority order.
`default_nettype none

module periodic_task_release_scheduler
  import ptrs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ptrs_tick_if.sink                in_chan_i,
  ptrs_result_if.source            out_chan_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic                  order_mode_q;
  logic [KeyW-1:0]       tick_step_q;
  key_arr_t              period_q;
  key_arr_t              cost_q;

  logic                  running_q;
  elapsed_arr_t          elapsed_q, elapsed_d;
  order_arr_t            order_q, order_d, sorted;

  logic                  out_valid_q;
  logic [MaskW-1:0]      mask_q, mask_d;
  order_arr_t            out_order_q;

  logic                  accept;
  logic [ElapsedW-1:0]   cur, base;
  logic [ElapsedW:0]     grown;

  ptrs_sort u_sort (
    .order_mode_i (order_mode_q),
    .period_i     (period_q),
    .cost_i       (cost_q),
    .order_o      (sorted)
  );

  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign accept          = in_chan_i.valid && in_chan_i.ready;

  always_comb begin
    order_d = running_q ? order_q : sorted;
    mask_d  = '0;
    for (int t = 0; t < Slots; t++) begin
      cur   = running_q ? elapsed_q[t] : {1'b0, period_q[t]};
      base  = cur;
      grown = '0;
      elapsed_d[t] = cur;
      if (in_chan_i.tick && t < TaskCount) begin
        if (cur >= {1'b0, period_q[t]}) begin
          mask_d[t] = 1'b1;
          base      = '0;
        end
        grown = {1'b0, base} + {{(ElapsedW + 1 - KeyW){1'b0}}, tick_step_q};
        elapsed_d[t] = grown[ElapsedW] ? ElapsedMax : grown[ElapsedW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= 1'b0;
      tick_step_q  <= TickStepRst;
      period_q[0]  <= Period0Rst;
      period_q[1]  <= Period1Rst;
      period_q[2]  <= Period2Rst;
      cost_q[0]    <= Cost0Rst;
      cost_q[1]    <= Cost1Rst;
      cost_q[2]    <= Cost2Rst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegOrderMode: order_mode_q <= cfg_data_i[0];
        RegTickStep:  tick_step_q  <= cfg_data_i;
        RegPeriod0:   period_q[0]  <= cfg_data_i;
        RegPeriod1:   period_q[1]  <= cfg_data_i;
        RegPeriod2:   period_q[2]  <= cfg_data_i;
        RegCost0:     cost_q[0]    <= cfg_data_i;
        RegCost1:     cost_q[1]    <= cfg_data_i;
        RegCost2:     cost_q[2]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        running_q <= 1'b1;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elapsed_q   <= elapsed_d;
      order_q     <= order_d;
      mask_q      <= mask_d;
      out_order_q <= order_d;
    end
  end

  assign out_chan_o.valid        = out_valid_q;
  assign out_chan_o.release_mask = mask_q;
  assign out_chan_o.first_task   = out_order_q[0];
  assign out_chan_o.second_task  = out_order_q[1];
  assign out_chan_o.third_task   = out_order_q[2];

endmodule

`default_nettype wire

// ===== hdl/ptrs_sort.sv =====
// Stable ascending sort of the task indexes by period or by worst-case cost.
// Depends on ptrs_pkg.
`default_nettype none

module ptrs_sort
  import ptrs_pkg::*;
(
  input  wire logic       order_mode_i,
  input  wire key_arr_t   period_i,
  input  wire key_arr_t   cost_i,
  output      order_arr_t order_o
);

  key_arr_t                  key;
  logic [Slots-1:0][1:0]     rank;

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      key[i] = order_mode_i ? cost_i[i] : period_i[i];
    end
    for (int i = 0; i < Slots; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < Slots; j++) begin
        if (i < TaskCount && j < TaskCount && j != i) begin
          if ((j < i) ? (key[j] <= key[i]) : (key[j] < key[i])) begin
            rank[i] = rank[i] + 2'd1;
          end
        end
      end
    end
    for (int i = 0; i < Slots; i++) begin
      order_o[i] = 2'(i);
    end
    for (int i = 0; i < TaskCount; i++) begin
      order_o[rank[i]] = 2'(i);
    end
  end

endmodule

`default_nettype wire
